[hdl/adcbi_pkg.sv]
// ----------------------------------------------------------------------------
// ADC bus interface package
// Shared widths, operation codes, register indexes, transfer structs and the
// sample-to-code conversion used by the ADC bus conversion interface.
// ----------------------------------------------------------------------------
`default_nettype none

package adcbi_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned TICK_W   = 10;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned CFG_IDX_W = 1;

    // Bus operation codes.
    localparam logic [OP_W-1:0] OP_RESET  = 3'd0;
    localparam logic [OP_W-1:0] OP_MODE   = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
    localparam logic [OP_W-1:0] OP_CS     = 3'd3;
    localparam logic [OP_W-1:0] OP_STROBE = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_TICKS = 1'd1;

    localparam logic [TICK_W-1:0] READ_TICKS_RST  = 10'd250;
    localparam logic [TICK_W-1:0] WRITE_TICKS_RST = 10'd136;

    localparam logic [CODE_W-1:0] IDLE_READ_VALUE = 8'hff;

    // Clamp limits of the signed sample.
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd16383;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd16384;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic [VALUE_W-1:0]         value;
        logic signed [SAMPLE_W-1:0] analog_sample;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] read_value;
        logic              ready_res;
        logic              interrupt;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic converting;
        logic ready;
    } status_t;

    typedef struct packed {
        logic              ovf;
        logic [CODE_W-1:0] code;
    } conv_t;

    // Clamp to -16384..16383 (either limit flags overflow), offset and keep
    // the top eight bits of the resulting 15-bit unsigned value.
    function automatic conv_t sample_to_code(input logic signed [SAMPLE_W-1:0] s);
        conv_t                      r;
        logic signed [SAMPLE_W-1:0] c;
        logic [SAMPLE_W-1:0]        off;
        begin
            r.ovf = 1'b0;
            c     = s;
            if (s >= SAMPLE_MAX) begin
                r.ovf = 1'b1;
                c     = SAMPLE_MAX;
            end else if (s <= SAMPLE_MIN) begin
                r.ovf = 1'b1;
                c     = SAMPLE_MIN;
            end
            off    = c - SAMPLE_MIN;
            r.code = off[14:7];
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/adcbi_core.sv]
// ----------------------------------------------------------------------------
// ADC bus interface core
// Converter state and the single-pass update applied for one bus operation.
// ----------------------------------------------------------------------------
`default_nettype none

module adcbi_core (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           step,
    input  adcbi_pkg::item_t              item,
    input  wire [adcbi_pkg::TICK_W-1:0]   read_ticks,
    input  wire [adcbi_pkg::TICK_W-1:0]   write_ticks,
    output adcbi_pkg::result_t            result,
    output adcbi_pkg::status_t            status
);

    logic [adcbi_pkg::CODE_W-1:0]   data_reg, data_next;
    logic [adcbi_pkg::NIBBLE_W-1:0] nibble_reg, nibble_next;
    logic                           cs_reg, cs_next;
    logic                           wr_mode_reg, wr_mode_next;
    logic                           req_reg, req_next;
    logic                           conv_reg, conv_next;
    logic [adcbi_pkg::TICK_W-1:0]   count_reg, count_next;
    logic                           ready_reg, ready_next;
    logic                           irq_reg, irq_next;
    logic                           ovf_reg, ovf_next;
    logic [adcbi_pkg::CODE_W-1:0]   rd;
    logic                           level;
    adcbi_pkg::conv_t               conv;

    assign level = (item.value != '0);
    assign conv  = adcbi_pkg::sample_to_code(item.analog_sample);

    always_comb begin
        data_next    = data_reg;
        nibble_next  = nibble_reg;
        cs_next      = cs_reg;
        wr_mode_next = wr_mode_reg;
        req_next     = req_reg;
        conv_next    = conv_reg;
        count_next   = count_reg;
        ready_next   = ready_reg;
        irq_next     = irq_reg;
        ovf_next     = ovf_reg;
        rd           = adcbi_pkg::IDLE_READ_VALUE;

        case (item.operation)
            adcbi_pkg::OP_RESET: begin
                data_next   = '0;
                nibble_next = '0;
                conv_next   = 1'b0;
                count_next  = '0;
                irq_next    = 1'b0;
                ovf_next    = 1'b0;
                ready_next  = 1'b1;
            end
            adcbi_pkg::OP_MODE: begin
                wr_mode_next = level;
            end
            adcbi_pkg::OP_WRITE: begin
                nibble_next = item.value[7:4];
                if (wr_mode_reg && !conv_reg) begin
                    ready_next = 1'b0;
                    irq_next   = 1'b0;
                    ovf_next   = 1'b0;
                    conv_next  = 1'b1;
                    count_next = write_ticks;
                end
            end
            adcbi_pkg::OP_CS: begin
                if (level && !cs_reg) begin
                    req_next   = 1'b1;
                    conv_next  = 1'b0;
                    count_next = '0;
                end
                cs_next = level;
            end
            adcbi_pkg::OP_STROBE: begin
                if (wr_mode_reg && cs_reg && !conv_reg) begin
                    ready_next = 1'b0;
                    irq_next   = 1'b0;
                    ovf_next   = 1'b0;
                    conv_next  = 1'b1;
                    count_next = write_ticks;
                end
            end
            adcbi_pkg::OP_READ: begin
                if (cs_reg) begin
                    if (!wr_mode_reg && req_reg && !conv_reg) begin
                        ready_next = 1'b0;
                        irq_next   = 1'b0;
                        ovf_next   = 1'b0;
                        conv_next  = 1'b1;
                        count_next = read_ticks;
                        req_next   = 1'b0;
                    end
                    rd = data_reg;
                end
            end
            adcbi_pkg::OP_TICK: begin
                if (conv_reg) begin
                    if (count_reg <= 10'd1) begin
                        // Conversion ends: take the sample.
                        if (wr_mode_reg) begin
                            data_next = {nibble_reg, conv.code[3:0]};
                        end else begin
                            data_next = conv.code;
                        end
                        nibble_next = conv.code[7:4];
                        ovf_next    = conv.ovf;
                        conv_next   = 1'b0;
                        count_next  = '0;
                        req_next    = 1'b0;
                        ready_next  = 1'b1;
                        irq_next    = 1'b1;
                    end else begin
                        count_next = count_reg - 10'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg    <= '0;
            nibble_reg  <= '0;
            cs_reg      <= 1'b0;
            wr_mode_reg <= 1'b0;
            req_reg     <= 1'b0;
            conv_reg    <= 1'b0;
            count_reg   <= '0;
            ready_reg   <= 1'b1;
            irq_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
        end else if (step) begin
            data_reg    <= data_next;
            nibble_reg  <= nibble_next;
            cs_reg      <= cs_next;
            wr_mode_reg <= wr_mode_next;
            req_reg     <= req_next;
            conv_reg    <= conv_next;
            count_reg   <= count_next;
            ready_reg   <= ready_next;
            irq_reg     <= irq_next;
            ovf_reg     <= ovf_next;
        end
    end

    assign result.read_value = rd;
    assign result.ready_res  = ready_next;
    assign result.interrupt  = irq_next;
    assign result.overflow   = ovf_next;

    assign status.converting = conv_reg;
    assign status.ready      = ready_reg;

endmodule

`default_nettype wire

[hdl/adc_bus_conversion_interface_unit.sv]
// ----------------------------------------------------------------------------
// ADC bus conversion interface unit
// Bus side of an 8-bit parallel ADC: bus operations and time ticks in, one
// status and read-data result out for every operation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  -------------------------------------
//  s_        in         s_tvalid / s_tready  tuser: operation; tdata: value, sample
//  m_        out        m_tvalid / m_tready  tdata: read_value, ready, irq, ovf
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data (tick counts)
//
//  One operation is accepted per cycle unless m_tready stalls the output. A
//  transfer on the s_ side is held in the input register; when the output
//  register is free or is being emptied, the converter state is updated and
//  the result is captured in the output register, which raises m_tvalid.
//  The only stall source is m_tready: while a result waits, the input
//  register fills and then s_tready drops. aresetn is synchronous and
//  active low; s_tready and cfg_ready are low while it is asserted, and
//  configuration writes are accepted in every cycle outside reset.
//
`default_nettype none

module adc_bus_conversion_interface_unit (
    input  wire        aclk,
    input  wire        aresetn,

    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [23:0] s_tdata,   // [7:0] value, [23:8] analog_sample
    input  wire [2:0]  s_tuser,   // [2:0] operation

    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata,  // [7:0] read_value, [8] ready_res,
                                  // [9] interrupt, [10] overflow, rest zero

    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [adcbi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [adcbi_pkg::TICK_W-1:0]    cfg_data
);

    // Conversion lengths written over the configuration channel.
    logic [adcbi_pkg::TICK_W-1:0] read_ticks_reg;
    logic [adcbi_pkg::TICK_W-1:0] write_ticks_reg;

    // Input register stage.
    logic              in_valid_reg;
    adcbi_pkg::item_t  in_item_reg;

    // Output register stage.
    logic              out_valid_reg;
    adcbi_pkg::result_t out_result_reg;

    adcbi_pkg::result_t core_result;
    adcbi_pkg::status_t core_status;
    logic              advance;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_ticks_reg  <= adcbi_pkg::READ_TICKS_RST;
            write_ticks_reg <= adcbi_pkg::WRITE_TICKS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                adcbi_pkg::CFG_READ_TICKS:  read_ticks_reg  <= cfg_data;
                adcbi_pkg::CFG_WRITE_TICKS: write_ticks_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held item moves on whenever the output register is free or is
    // being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.operation     <= s_tuser;
            in_item_reg.value         <= s_tdata[7:0];
            in_item_reg.analog_sample <= s_tdata[23:8];
        end
    end

    adcbi_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (in_item_reg),
        .read_ticks  (read_ticks_reg),
        .write_ticks (write_ticks_reg),
        .result      (core_result),
        .status      (core_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_result_reg.overflow, out_result_reg.interrupt,
                       out_result_reg.ready_res, out_result_reg.read_value};

    // A conversion in progress always has the ready flag low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        core_status.converting |-> !core_status.ready)
        else $error("converter busy while ready flag is set");

    // The interrupt is only raised together with the ready flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!out_result_reg.interrupt || out_result_reg.ready_res))
        else $error("interrupt reported without ready");

    // Overflow belongs to a finished conversion, which also raised the interrupt.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!out_result_reg.overflow || out_result_reg.interrupt))
        else $error("overflow reported without interrupt");

    // With the output register empty the input side can never be stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// ADC bus conversion interface testbench
// Sends bus operations and ticks into the converter in random bursts, stalls
// the result side on its own pattern, and checks every status transfer
// against an in-bench model of the converter state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    // Operation code 7 is not decoded by the block; it must leave the state
    // alone and report like any other non-read operation.
    localparam logic [adcbi_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    // Offset that moves a clamped sample into the unsigned 15-bit range.
    localparam logic [adcbi_pkg::SAMPLE_W:0] SAMPLE_BIAS = 17'd16384;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // ------------------------------------------------------------------------
    // Clock, reset and the inputs of the block, all known from time zero.
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata  = '0;   // [7:0] value, [23:8] analog_sample
    logic [2:0]           s_tuser  = '0;   // [2:0] operation

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;         // [7:0] read_value, [8] ready_res,
                                           // [9] interrupt, [10] overflow

    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [adcbi_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [adcbi_pkg::TICK_W-1:0]        cfg_data  = '0;

    adc_bus_conversion_interface_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Converter model. It mirrors the architectural state of the block and is
    // advanced once for every operation accepted on the s_ side.
    // ------------------------------------------------------------------------
    logic [adcbi_pkg::CODE_W-1:0]   adc_code;
    logic [adcbi_pkg::NIBBLE_W-1:0] adc_nibble;
    logic                           adc_cs;
    logic                           adc_wr_mode;
    logic                           adc_requested;
    logic                           adc_busy;
    logic [adcbi_pkg::TICK_W-1:0]   adc_count;
    logic                           adc_ready;
    logic                           adc_irq;
    logic                           adc_ovf;
    logic [adcbi_pkg::TICK_W-1:0]   adc_read_ticks;
    logic [adcbi_pkg::TICK_W-1:0]   adc_write_ticks;

    // Status words still owed by the block, oldest first.
    adcbi_pkg::result_t conversion_status_due[$];
    // Operations waiting for the sender, oldest first.
    adcbi_pkg::item_t   bus_ops_to_send[$];

    int fault_count  = 0;
    int cycle_count  = 0;
    int queued_ops   = 0;
    int accepted_ops = 0;
    int read_eff     = 250;
    int write_eff    = 136;

    // Handshake records from the last rising edge, used by the falling-edge
    // drivers so that they never look at a registered output mid-step.
    logic op_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    function automatic void arm_conversion(input logic [adcbi_pkg::TICK_W-1:0] ticks);
        adc_ready = 1'b0;
        adc_irq   = 1'b0;
        adc_ovf   = 1'b0;
        adc_busy  = 1'b1;
        adc_count = ticks;
    endfunction

    function automatic adcbi_pkg::result_t adc_bus_access(input adcbi_pkg::item_t bus_op);
        adcbi_pkg::result_t                    res;
        logic                                  level;
        logic                                  clipped;
        logic signed [adcbi_pkg::SAMPLE_W-1:0] clamped;
        logic [adcbi_pkg::SAMPLE_W:0]          biased;
        logic [adcbi_pkg::CODE_W-1:0]          code;
        level          = |bus_op.value;
        res.read_value = adcbi_pkg::IDLE_READ_VALUE;
        case (bus_op.operation)
            adcbi_pkg::OP_RESET: begin
                // Mode, chip select and a pending request survive this.
                adc_code   = '0;
                adc_nibble = '0;
                adc_busy   = 1'b0;
                adc_count  = '0;
                adc_irq    = 1'b0;
                adc_ovf    = 1'b0;
                adc_ready  = 1'b1;
            end
            adcbi_pkg::OP_MODE: begin
                adc_wr_mode = level;
            end
            adcbi_pkg::OP_WRITE: begin
                adc_nibble = bus_op.value[7:4];
                if (adc_wr_mode && !adc_busy) arm_conversion(adc_write_ticks);
            end
            adcbi_pkg::OP_CS: begin
                // A rising select requests a conversion and drops the one
                // running, but leaves the flags as they are.
                if (level && !adc_cs) begin
                    adc_requested = 1'b1;
                    adc_busy      = 1'b0;
                    adc_count     = '0;
                end
                adc_cs = level;
            end
            adcbi_pkg::OP_STROBE: begin
                if (adc_wr_mode && adc_cs && !adc_busy) arm_conversion(adc_write_ticks);
            end
            adcbi_pkg::OP_READ: begin
                if (adc_cs) begin
                    if (!adc_wr_mode && adc_requested && !adc_busy) begin
                        arm_conversion(adc_read_ticks);
                        adc_requested = 1'b0;
                    end
                    res.read_value = adc_code;
                end
            end
            adcbi_pkg::OP_TICK: begin
                if (adc_busy) begin
                    // A count of zero or one ends the conversion on this tick.
                    if (adc_count <= 1) begin
                        clipped = 1'b0;
                        clamped = bus_op.analog_sample;
                        if (clamped >= adcbi_pkg::SAMPLE_MAX) begin
                            clipped = 1'b1;
                            clamped = adcbi_pkg::SAMPLE_MAX;
                        end else if (clamped <= adcbi_pkg::SAMPLE_MIN) begin
                            clipped = 1'b1;
                            clamped = adcbi_pkg::SAMPLE_MIN;
                        end
                        biased = {clamped[adcbi_pkg::SAMPLE_W-1], clamped} + SAMPLE_BIAS;
                        code   = biased[14:7];
                        if (adc_wr_mode) adc_code = {adc_nibble, code[3:0]};
                        else adc_code = code;
                        adc_nibble    = code[7:4];
                        adc_ovf       = clipped;
                        adc_busy      = 1'b0;
                        adc_count     = '0;
                        adc_requested = 1'b0;
                        adc_ready     = 1'b1;
                        adc_irq       = 1'b1;
                    end else begin
                        adc_count = adc_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.ready_res = adc_ready;
        res.interrupt = adc_irq;
        res.overflow  = adc_ovf;
        return res;
    endfunction

    task automatic report_fault(input string what, input adcbi_pkg::result_t want,
                                input logic [15:0] got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $write("%0t: %s: read_value exp %02h got %02h, ready exp %0b got %0b, ",
                   $realtime, what, want.read_value, got[7:0], want.ready_res, got[8]);
            $display("irq exp %0b got %0b, ovf exp %0b got %0b, pad got %02h",
                     want.interrupt, got[9], want.overflow, got[10], got[15:11]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Configuration and
    // operation transfers update the model; result transfers are compared
    // with the oldest status word still owed.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        adcbi_pkg::result_t want;
        op_taken  <= aresetn && s_tvalid && s_tready;
        cfg_taken <= aresetn && cfg_valid && cfg_ready;
        if (!aresetn) begin
            adc_code        = '0;
            adc_nibble      = '0;
            adc_cs          = 1'b0;
            adc_wr_mode     = 1'b0;
            adc_requested   = 1'b0;
            adc_busy        = 1'b0;
            adc_count       = '0;
            adc_ready       = 1'b1;
            adc_irq         = 1'b0;
            adc_ovf         = 1'b0;
            adc_read_ticks  = adcbi_pkg::READ_TICKS_RST;
            adc_write_ticks = adcbi_pkg::WRITE_TICKS_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    adcbi_pkg::CFG_READ_TICKS:  adc_read_ticks  = cfg_data;
                    adcbi_pkg::CFG_WRITE_TICKS: adc_write_ticks = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                accepted_ops++;
                conversion_status_due.push_back(adc_bus_access(
                    '{operation: s_tuser, value: s_tdata[7:0],
                      analog_sample: s_tdata[23:8]}));
            end
            if (m_tvalid && m_tready) begin
                if (conversion_status_due.size() == 0) begin
                    want = '1;
                    report_fault("result with nothing owed", want, m_tdata);
                end else begin
                    want = conversion_status_due.pop_front();
                    if (m_tdata !== {5'b0, want.overflow, want.interrupt, want.ready_res,
                                     want.read_value})
                        report_fault("status mismatch", want, m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. A new
    // operation is presented only when the previous one was transferred, so
    // tvalid never drops while an operation is waiting.
    // ------------------------------------------------------------------------
    int               burst_left = 0;
    int               gap_left   = 0;
    adcbi_pkg::item_t next_op;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || op_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (bus_ops_to_send.size() > 0) begin
                next_op = bus_ops_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_op.operation;
                s_tdata  <= {next_op.analog_sample, next_op.value};
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: alternates windows with no stalls, while bit 8 of its cycle
    // count is low, and windows in which short stalls start at random.
    // ------------------------------------------------------------------------
    int rx_cycle   = 0;
    int stall_left = 0;

    always @(negedge aclk) begin
        rx_cycle++;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_cycle[8] && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // A hung handshake must not run forever.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [adcbi_pkg::OP_W-1:0] op,
                           input logic [adcbi_pkg::VALUE_W-1:0] val,
                           input logic signed [adcbi_pkg::SAMPLE_W-1:0] smp);
        bus_ops_to_send.push_back('{operation: op, value: val, analog_sample: smp});
        queued_ops++;
    endtask

    // Samples lean toward the clamp limits and the ends of the 16-bit range.
    function automatic logic signed [adcbi_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return adcbi_pkg::SAMPLE_MAX;
            3:       return adcbi_pkg::SAMPLE_MAX - 1;
            4:       return adcbi_pkg::SAMPLE_MIN;
            5:       return adcbi_pkg::SAMPLE_MIN + 1;
            6:       return 16'sh0000;
            default: return adcbi_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Usually exactly the programmed count, sometimes past it, sometimes
    // short so that the next run finds the converter still busy.
    function automatic int pick_tick_count(input int eff);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, eff - 1);
            1:       return eff + $urandom_range(1, 3);
            default: return eff;
        endcase
    endfunction

    function automatic logic [adcbi_pkg::VALUE_W-1:0] any_value();
        return adcbi_pkg::VALUE_W'($urandom);
    endfunction

    function automatic logic [adcbi_pkg::VALUE_W-1:0] high_level();
        return adcbi_pkg::VALUE_W'($urandom_range(1, 255));
    endfunction

    task automatic send_ticks(input int n);
        repeat (n) send_op(adcbi_pkg::OP_TICK, any_value(), pick_sample());
    endtask

    // Read mode: select edge requests, the first read starts the conversion.
    task automatic queue_read_run();
        send_op(adcbi_pkg::OP_MODE, 8'h00, pick_sample());
        if ($urandom_range(0, 5) != 0) send_op(adcbi_pkg::OP_CS, 8'h00, pick_sample());
        send_op(adcbi_pkg::OP_CS, high_level(), pick_sample());
        send_op(adcbi_pkg::OP_READ, any_value(), pick_sample());
        if ($urandom_range(0, 3) == 0) send_op(adcbi_pkg::OP_READ, any_value(), pick_sample());
        send_ticks(pick_tick_count(read_eff));
        send_op(adcbi_pkg::OP_READ, any_value(), pick_sample());
    endtask

    // Write-read mode: a data write or a strobe starts the conversion.
    task automatic queue_write_run();
        send_op(adcbi_pkg::OP_MODE, high_level(), pick_sample());
        if ($urandom_range(0, 3) == 0) send_op(adcbi_pkg::OP_CS, 8'h00, pick_sample());
        if ($urandom_range(0, 5) != 0) send_op(adcbi_pkg::OP_CS, high_level(), pick_sample());
        if ($urandom_range(0, 1) == 0) send_op(adcbi_pkg::OP_WRITE, any_value(), pick_sample());
        else send_op(adcbi_pkg::OP_STROBE, any_value(), pick_sample());
        if ($urandom_range(0, 3) == 0) send_op(adcbi_pkg::OP_WRITE, any_value(), pick_sample());
        send_ticks(pick_tick_count(write_eff));
        send_op(adcbi_pkg::OP_READ, any_value(), pick_sample());
    endtask

    task automatic queue_noise();
        logic [adcbi_pkg::VALUE_W-1:0] val;
        repeat ($urandom_range(1, 4)) begin
            val = ($urandom_range(0, 2) == 0) ? 8'h00 : any_value();
            send_op(adcbi_pkg::OP_W'($urandom_range(0, 7)), val, pick_sample());
        end
    endtask

    task automatic queue_mix(input int count);
        int stop_at;
        stop_at = queued_ops + count;
        while (queued_ops < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_read_run();
                4, 5, 6:    queue_write_run();
                default:    queue_noise();
            endcase
        end
    endtask

    // Waits until every queued operation was transferred and its status
    // returned, then lets the two-stage pipeline empty.
    task automatic settle_bus();
        while (accepted_ops != queued_ops || conversion_status_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input logic [adcbi_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [adcbi_pkg::TICK_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_ticks(input logic [adcbi_pkg::TICK_W-1:0] rd,
                                 input logic [adcbi_pkg::TICK_W-1:0] wr);
        settle_bus();
        write_register(adcbi_pkg::CFG_READ_TICKS, rd);
        write_register(adcbi_pkg::CFG_WRITE_TICKS, wr);
        read_eff  = (rd == 0) ? 1 : rd;
        write_eff = (wr == 0) ? 1 : wr;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset tick counts: nothing completes, so this covers the control
        // paths. An idle tick and the undecoded code must change nothing.
        send_op(adcbi_pkg::OP_TICK, 8'h00, 16'sh7fff);
        send_op(OP_UNUSED, 8'hff, 16'sh8000);
        send_op(adcbi_pkg::OP_READ, 8'h00, 16'sh0000);    // not selected, reads all ones
        send_op(adcbi_pkg::OP_CS, 8'h01, 16'sh0000);      // rising select requests
        send_op(adcbi_pkg::OP_READ, 8'hff, 16'sh0000);    // starts a read conversion
        send_op(adcbi_pkg::OP_READ, 8'h00, 16'sh0000);    // busy, start is ignored
        send_op(adcbi_pkg::OP_TICK, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_CS, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_CS, 8'h80, 16'sh0000);      // cancels, ready stays low
        send_op(adcbi_pkg::OP_TICK, 8'hff, 16'sh7fff);    // nothing running any more
        send_op(adcbi_pkg::OP_RESET, 8'hff, 16'sh0000);
        send_op(adcbi_pkg::OP_MODE, 8'h40, 16'sh0000);
        send_op(adcbi_pkg::OP_WRITE, 8'h5a, 16'sh0000);   // write-read conversion starts
        send_op(adcbi_pkg::OP_STROBE, 8'h00, 16'sh0000);  // busy, ignored
        send_op(adcbi_pkg::OP_RESET, 8'h00, 16'sh0000);

        // A zero read count behaves as one tick.
        program_ticks(10'd0, 10'd1);
        send_op(adcbi_pkg::OP_MODE, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_CS, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_CS, 8'hff, 16'sh0000);
        send_op(adcbi_pkg::OP_READ, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_TICK, 8'h00, adcbi_pkg::SAMPLE_MAX);  // exactly at the limit
        send_op(adcbi_pkg::OP_READ, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_MODE, 8'h01, 16'sh0000);
        send_op(adcbi_pkg::OP_WRITE, 8'h30, 16'sh0000);
        send_op(adcbi_pkg::OP_TICK, 8'h00, 16'sh8000);    // far below the lower limit
        send_op(adcbi_pkg::OP_STROBE, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_TICK, 8'h00, adcbi_pkg::SAMPLE_MAX - 1);
        send_op(adcbi_pkg::OP_READ, 8'h00, 16'sh0000);

        program_ticks(10'd3, 10'd5);
        queue_mix(270);
        program_ticks(10'd1, 10'd1);
        queue_mix(240);
        program_ticks(adcbi_pkg::TICK_W'($urandom_range(2, 12)),
                      adcbi_pkg::TICK_W'($urandom_range(2, 12)));
        queue_mix(270);

        // Largest counts: a read conversion and a write-read conversion,
        // each cut short by the reset operation after a few ticks.
        program_ticks(10'd1023, 10'd1023);
        send_op(adcbi_pkg::OP_MODE, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_CS, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_CS, 8'h01, 16'sh0000);
        send_op(adcbi_pkg::OP_READ, 8'h00, 16'sh0000);
        send_ticks(8);
        send_op(adcbi_pkg::OP_READ, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_RESET, 8'h00, 16'sh0000);
        send_op(adcbi_pkg::OP_MODE, 8'h01, 16'sh0000);
        send_op(adcbi_pkg::OP_WRITE, 8'hc3, 16'sh0000);
        send_ticks(5);
        send_op(adcbi_pkg::OP_RESET, 8'h00, 16'sh0000);

        program_ticks(10'd8, 10'd2);
        queue_mix(270);

        settle_bus();
        repeat (8) @(negedge aclk);
        if (fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
